>>> rtl/chisq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chi-square distance package
// Widths, derived divider sizes and sequencer states shared by the block.
// ----------------------------------------------------------------------------
package chisq_pkg;

   localparam int IN_BITS    = 16;
   localparam int OUT_BITS   = 48;

   localparam int COUNT_BITS = 16;
   localparam int FRAC_BITS  = 8;
   localparam int DIST_BITS  = 48;

   // term < 2^(COUNT_BITS-1) * 2^FRAC_BITS, so this many quotient bits suffice
   localparam int QUO_BITS   = COUNT_BITS + FRAC_BITS;
   localparam int SUM_BITS   = COUNT_BITS + 1;
   localparam int REM_BITS   = COUNT_BITS + 2;
   localparam int SQ_BITS    = 2 * COUNT_BITS;
   localparam int CMP_BITS   = ((QUO_BITS > DIST_BITS) ? QUO_BITS : DIST_BITS) + 1;
   localparam int STEP_BITS  = $clog2(QUO_BITS);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_DIVIDE,
      ST_ACCUM,
      ST_OUTPUT
   } state_type;

endpackage

>>> rtl/chi_square_histogram_distance.sv
`timescale 1ns / 1ps
// Sequencing: after the input transfer a bin is squared, divided (skipped on a zero sum)
//   and accumulated for the minima term, then the maxima term; a last bin then loads the
//   result register. A new bin is taken only once the last is done, the shared radix-2
//   divider serving both terms; a stalled result holds the next last bin in output.
// Reset (synchronous, active high) clears the accumulator, the saturation flag,
//   the sequencer and the result valid.
// ----------------------------------------------------------------------------
// Chi-square histogram distance
// Accumulates 0.5*(a-b)^2/(a+b) per bin for minima and maxima counts in
// saturating fixed point and returns the total on the last bin.
// ----------------------------------------------------------------------------
module chi_square_histogram_distance (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [chisq_pkg::IN_BITS-1:0]     req_ref_min_count,
   input  logic [chisq_pkg::IN_BITS-1:0]     req_ref_max_count,
   input  logic [chisq_pkg::IN_BITS-1:0]     req_query_min_count,
   input  logic [chisq_pkg::IN_BITS-1:0]     req_query_max_count,
   input  logic                              req_last_bin,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [chisq_pkg::OUT_BITS-1:0]    rsp_distance,
   output logic                              rsp_saturated
);
   import chisq_pkg::*;

   state_type               state_ff, state_in;
   logic                    term_ff, term_in;
   logic [COUNT_BITS-1:0]   rmin_ff, rmax_ff, qmin_ff, qmax_ff;
   logic                    last_ff;
   logic [REM_BITS-1:0]     den_ff, den_in;
   logic [REM_BITS-1:0]     rem_ff, rem_in;
   logic [QUO_BITS-1:0]     num_ff, num_in;
   logic [STEP_BITS-1:0]    step_ff, step_in;
   logic [DIST_BITS-1:0]    acc_ff, acc_in;
   logic                    sat_ff, sat_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [OUT_BITS-1:0]     rsp_distance_ff;
   logic                    rsp_saturated_ff;
   logic                    rsp_load;

   logic [COUNT_BITS-1:0]   op_a, op_b, diff;
   logic [SUM_BITS-1:0]     sum;
   logic [SQ_BITS-1:0]      sq;
   logic [REM_BITS:0]       shifted;
   logic [REM_BITS+1:0]     trial;
   logic                    borrow;
   logic                    clip;
   logic [DIST_BITS-1:0]    term;
   logic [DIST_BITS:0]      acc_sum;
   logic [DIST_BITS-1:0]    dist_max;

   logic req_xfer, rsp_xfer;

   assign req_xfer = req_valid && !req_stall;
   assign rsp_xfer = rsp_valid_ff && !rsp_stall;

   assign op_a = term_ff ? rmax_ff : rmin_ff;
   assign op_b = term_ff ? qmax_ff : qmin_ff;
   assign diff = (op_a >= op_b) ? (op_a - op_b) : (op_b - op_a);
   assign sum  = {1'b0, op_a} + {1'b0, op_b};
   assign sq   = SQ_BITS'(diff) * SQ_BITS'(diff);

   assign shifted = {rem_ff, num_ff[QUO_BITS-1]};
   assign trial   = {1'b0, shifted} - {2'b00, den_ff};
   assign borrow  = trial[REM_BITS+1];

   assign dist_max = '1;
   assign clip     = CMP_BITS'(num_ff) > CMP_BITS'(dist_max);
   assign term     = clip ? dist_max : DIST_BITS'(num_ff);
   assign acc_sum  = {1'b0, acc_ff} + {1'b0, term};

   always_comb begin
      state_in     = state_ff;
      term_in      = term_ff;
      den_in       = den_ff;
      rem_in       = rem_ff;
      num_in       = num_ff;
      step_in      = step_ff;
      acc_in       = acc_ff;
      sat_in       = sat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_xfer;
      rsp_load     = 1'b0;
      req_stall    = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               term_in  = 1'b0;
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            den_in  = {sum, 1'b0};
            rem_in  = REM_BITS'(sq[SQ_BITS-1:COUNT_BITS]);
            num_in  = QUO_BITS'(sq[COUNT_BITS-1:0]) << FRAC_BITS;
            step_in = STEP_BITS'(QUO_BITS - 1);
            if (sum == '0) begin
               num_in   = '0;
               state_in = ST_ACCUM;
            end else begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            rem_in = borrow ? shifted[REM_BITS-1:0] : trial[REM_BITS-1:0];
            num_in = {num_ff[QUO_BITS-2:0], !borrow};
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               state_in = ST_ACCUM;
            end
         end
         ST_ACCUM: begin
            if (acc_sum[DIST_BITS]) begin
               acc_in = dist_max;
               sat_in = 1'b1;
            end else begin
               acc_in = acc_sum[DIST_BITS-1:0];
            end
            if (clip) begin
               sat_in = 1'b1;
            end
            priority if (!term_ff) begin
               term_in  = 1'b1;
               state_in = ST_SQUARE;
            end else if (last_ff) begin
               state_in = ST_OUTPUT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_OUTPUT: begin
            if (!rsp_valid_ff || rsp_xfer) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               acc_in       = '0;
               sat_in       = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         term_ff      <= 1'b0;
         acc_ff       <= '0;
         sat_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         term_ff      <= term_in;
         acc_ff       <= acc_in;
         sat_ff       <= sat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      num_ff  <= num_in;
      step_ff <= step_in;
      if (req_xfer) begin
         rmin_ff <= COUNT_BITS'(req_ref_min_count);
         rmax_ff <= COUNT_BITS'(req_ref_max_count);
         qmin_ff <= COUNT_BITS'(req_query_min_count);
         qmax_ff <= COUNT_BITS'(req_query_max_count);
         last_ff <= req_last_bin;
      end
      if (rsp_load) begin
         rsp_distance_ff  <= OUT_BITS'(acc_ff);
         rsp_saturated_ff <= sat_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_distance  = rsp_distance_ff;
   assign rsp_saturated = rsp_saturated_ff;

endmodule

>>> rtl/chisq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chi-square distance port checker
// Port-level checks on sequencing and result delivery, bound to the top level.
// ----------------------------------------------------------------------------
module chisq_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  logic                              req_last_bin,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic [chisq_pkg::OUT_BITS-1:0]    rsp_distance,
   input  logic                              rsp_saturated
);
   import chisq_pkg::*;

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("block not idle after reset");

   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input taken while a bin is in progress");

   a_result_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without preceding work");

   a_result_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         rsp_valid && $stable(rsp_distance) && $stable(rsp_saturated))
      else $error("stalled result changed");

   a_no_early_result: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && !req_last_bin) |=> !$rose(rsp_valid))
      else $error("result raised right after a non-final bin");

endmodule

bind chi_square_histogram_distance chisq_checker u_chisq_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .req_last_bin  (req_last_bin),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_distance  (rsp_distance),
   .rsp_saturated (rsp_saturated)
);
